[rtl/core/ksft_pkg.sv]
package ksft_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_FRICTION  = 3'd0;
   localparam logic [2:0] CSR_STOP_VEL  = 3'd1;
   localparam logic [2:0] CSR_IDLE_GAP  = 3'd2;
   localparam logic [2:0] CSR_MIN_VEL   = 3'd3;
   localparam logic [2:0] CSR_MAX_VEL   = 3'd4;

   localparam logic [15:0] FRICTION_RST = 16'd65405;
   localparam logic [30:0] STOP_VEL_RST = 31'd655;
   localparam logic [15:0] IDLE_GAP_RST = 16'd50;
   localparam logic [30:0] MIN_VEL_RST  = 31'd6554;
   localparam logic [30:0] MAX_VEL_RST  = 31'd524288;

   localparam logic [16:0] Q16_ONE = 17'd65536;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_EST,
      ST_EMIT,
      ST_POW_MUL,
      ST_POW_SQR,
      ST_DECAY,
      ST_DONE
   } state_type;

   // request to the shared multiplier
   typedef struct packed {
      logic        start;
      logic [47:0] a;
      logic [31:0] b;
   } mul_req_type;

endpackage

[rtl/core/ksft_mul.sv]
// Shared 48x32 multiplier, computed as two 48x16 partial products in two
// phases. done pulses with the registered product.
module ksft_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  ksft_pkg::mul_req_type req,
   output logic                 done,
   output logic [79:0]          prod
);
   import ksft_pkg::*;

   logic [47:0] a_ff, a_in;
   logic [15:0] bh_ff, bh_in;
   logic [79:0] p_ff, p_in;
   logic [1:0]  ph_ff, ph_in;

   // phase 1: low half; phase 2: add high half
   always_comb begin
      a_in  = a_ff;
      bh_in = bh_ff;
      p_in  = p_ff;
      ph_in = 2'd0;
      if (req.start) begin
         a_in  = req.a;
         bh_in = req.b[31:16];
         p_in  = 80'(req.a * req.b[15:0]);
         ph_in = 2'd1;
      end else if (ph_ff == 2'd1) begin
         p_in  = p_ff + (80'(a_ff * bh_ff) << 16);
         ph_in = 2'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 2'd0;
      end else begin
         ph_ff <= ph_in;
      end
      a_ff  <= a_in;
      bh_ff <= bh_in;
      p_ff  <= p_in;
   end

   assign done = (ph_ff == 2'd2);
   assign prod = p_ff;

   always_ff @(posedge clock) begin
      if (!reset && req.start && ph_ff == 2'd1)
         $error("multiplier restarted mid operation");
   end
endmodule

[rtl/core/ksft_div.sv]
// Restoring divider, one quotient bit per cycle (40-bit dividend, 32-bit divisor).
module ksft_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [39:0] quot
);
   import ksft_pkg::*;

   logic [39:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = '0;
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = 6'd40; busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff[31:0], q_ff[39]};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[38:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

[rtl/core/kinetic_scroll_fling_tracker_top.sv]
// Kinetic scroll fling tracker. One item is taken at a time; req_stall is high
// from acceptance until the result leaves the output register. A touchpad or
// other sample, and an idle tick, go straight to the response. A
// gesture-ending tick walks the window, runs a serial divide and, if the
// estimate reaches the minimum velocity, the fling step: the shared multiplier
// is used once for the emitted distance, up to twice per bit of the elapsed
// time for the square-and-multiply power (the loop runs while bits remain, so
// up to 32 bits), and once for the decay. A later tick in a fling with a new
// time runs the fling step alone.
module kinetic_scroll_fling_tracker_top #(
   parameter int WINDOW_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic signed [23:0] req_sample_delta,
   input  logic        req_is_touchpad,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_scroll_delta,
   output logic        rsp_fling_active,
   output logic        rsp_gesture_watching,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ksft_pkg::*;

   localparam int IW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

   // window pointer wrap by compare and subtract
   function automatic logic [IW-1:0] wrap_ptr(input logic [SW-1:0] s);
      logic [SW-1:0] r;
      r = s;
      if (r >= SW'(2 * WINDOW_DEPTH)) r = r - SW'(2 * WINDOW_DEPTH);
      else if (r >= SW'(WINDOW_DEPTH)) r = r - SW'(WINDOW_DEPTH);
      return r[IW-1:0];
   endfunction

   // configuration
   logic [15:0] friction_ff, idle_gap_ff;
   logic [30:0] stop_vel_ff, min_vel_ff, max_vel_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         friction_ff <= FRICTION_RST;
         stop_vel_ff <= STOP_VEL_RST;
         idle_gap_ff <= IDLE_GAP_RST;
         min_vel_ff  <= MIN_VEL_RST;
         max_vel_ff  <= MAX_VEL_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRICTION: friction_ff <= csr_data[15:0];
            CSR_STOP_VEL: stop_vel_ff <= csr_data[30:0];
            CSR_IDLE_GAP: idle_gap_ff <= csr_data[15:0];
            CSR_MIN_VEL:  min_vel_ff  <= csr_data[30:0];
            CSR_MAX_VEL:  max_vel_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // window memories (circular; head is oldest)
   logic signed [23:0] wdelta_mem [WINDOW_DEPTH];
   logic [31:0]        wtime_mem  [WINDOW_DEPTH];
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   // control state
   state_type   state_ff, state_in;
   logic        watching_ff, watching_in;
   logic        fling_ff, fling_in;
   logic        vneg_ff, vneg_in;
   logic [31:0] vmag_ff, vmag_in;
   logic [31:0] last_sample_ff, last_sample_in;
   logic [31:0] last_tick_ff, last_tick_in;
   logic        tick_valid_ff, tick_valid_in;

   // working registers
   logic [31:0] now_ff, now_in;
   logic [31:0] dt_ff, dt_in;
   logic [31:0] n_ff, n_in;
   logic [16:0] acc_ff, acc_in;
   logic [16:0] base_ff, base_in;
   logic signed [35:0] total_ff, total_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [31:0] t0_ff, t0_in;
   logic [31:0] tlast_ff, tlast_in;
   logic        mul_wait_ff, mul_wait_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_delta_ff, out_delta_in;
   logic        out_fling_ff, out_watch_ff;

   // shared units
   mul_req_type mreq;
   logic        mdone;
   logic [79:0] mprod;
   logic        dstart;
   logic [39:0] ddividend;
   logic [39:0] dquot;
   logic        ddone;
   logic [31:0] span;
   logic [35:0] tmag;

   ksft_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .done(mdone), .prod(mprod));
   ksft_div u_div (.clock(clock), .reset(reset), .start(dstart), .dividend(ddividend),
                   .divisor(span), .done(ddone), .quot(dquot));

   wire accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;

   wire [IW-1:0] wr_ptr = wrap_ptr(SW'(head_ff) + SW'(count_ff));
   wire [IW-1:0] rd_ptr = wrap_ptr(SW'(head_ff) + SW'(idx_ff));
   wire [IW-1:0] last_ptr = wrap_ptr(SW'(head_ff) + SW'(count_ff) - SW'(1));
   wire          full = (count_ff == DEPTH_C);
   wire [31:0]   idle_time = req_time_ms - last_sample_ff;

   logic signed [23:0] rd_delta_ff;
   logic [31:0]        rd_time_ff;

   // window write on touchpad sample, registered reads for the sum walk
   always_ff @(posedge clock) begin
      if (accept && !req_operation && req_is_touchpad) begin
         wdelta_mem[full ? head_ff : wr_ptr] <= req_sample_delta;
         wtime_mem[full ? head_ff : wr_ptr]  <= req_time_ms;
      end
      rd_delta_ff <= wdelta_mem[rd_ptr];
      rd_time_ff  <= wtime_mem[state_ff == ST_IDLE ? head_ff : last_ptr];
   end

   assign span = tlast_ff - t0_ff;
   assign tmag = total_ff[35] ? 36'(-total_ff) : 36'(total_ff);
   assign ddividend = {tmag[31:0], 8'd0} + 40'(span[31:1]);

   // estimate is zero with fewer than two samples or a zero span
   wire        est_valid = (count_ff >= CW'(2)) && (span != 32'd0);
   wire [39:0] est_vel = est_valid ? dquot : 40'd0;
   wire        est_go = (est_vel >= {9'd0, min_vel_ff});

   logic [31:0] emit_mag;
   assign emit_mag = 32'(mprod[63:8] + 56'(mprod[7]));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation && !fling_ff && watching_ff &&
                idle_time >= {16'd0, idle_gap_ff}) state_in = ST_SUM;
            else if (accept && req_operation && fling_ff && tick_valid_ff &&
                     req_time_ms != last_tick_ff) state_in = ST_EMIT;
            else if (accept) state_in = ST_DONE;
         end
         ST_SUM: begin
            if (idx_ff == count_ff + CW'(1)) state_in = ST_DIV;
         end
         ST_DIV:     if (ddone) state_in = ST_EST;
         ST_EST: begin
            if (est_go) state_in = ST_EMIT;
            else state_in = ST_DONE;
         end
         ST_EMIT:    if (mdone) state_in = (n_ff == 0) ? ST_DECAY : ST_POW_MUL;
         ST_POW_MUL: if (mdone || !n_ff[0]) state_in = ST_POW_SQR;
         ST_POW_SQR: if (mdone) state_in = (n_ff[31:1] == 0) ? ST_DECAY : ST_POW_MUL;
         ST_DECAY:   if (mdone) state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in = head_ff; count_in = count_ff;
      watching_in = watching_ff; fling_in = fling_ff;
      vneg_in = vneg_ff; vmag_in = vmag_ff;
      last_sample_in = last_sample_ff; last_tick_in = last_tick_ff;
      tick_valid_in = tick_valid_ff;
      now_in = now_ff; dt_in = dt_ff; n_in = n_ff;
      acc_in = acc_ff; base_in = base_ff; total_in = total_ff;
      idx_in = idx_ff; t0_in = t0_ff; tlast_in = tlast_ff;
      mul_wait_in = mul_wait_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_delta_in = out_delta_ff;
      mreq = '0;
      dstart = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in = req_time_ms;
               out_delta_in = '0;
               mul_wait_in = 1'b0;
               if (!req_operation) begin
                  fling_in = 1'b0; vmag_in = '0; vneg_in = 1'b0; tick_valid_in = 1'b0;
                  if (!req_is_touchpad) begin
                     count_in = '0; watching_in = 1'b0; head_in = '0;
                  end else begin
                     if (full) head_in = wrap_ptr(SW'(head_ff) + SW'(1));
                     else count_in = count_ff + CW'(1);
                     last_sample_in = req_time_ms;
                     watching_in = 1'b1;
                  end
               end else if (fling_ff) begin
                  dt_in = tick_valid_ff ? req_time_ms - last_tick_ff : 32'd0;
                  n_in = dt_in;
                  last_tick_in = req_time_ms;
                  tick_valid_in = 1'b1;
               end else if (watching_ff && idle_time >= {16'd0, idle_gap_ff}) begin
                  dt_in = idle_time; n_in = idle_time;
                  total_in = '0; idx_in = CW'(1);
                  t0_in = rd_time_ff;
               end
            end
         end
         ST_SUM: begin
            // read data for idx arrives in the cycle after idx
            idx_in = idx_ff + CW'(1);
            if (idx_ff >= CW'(2) && idx_ff <= count_ff)
               total_in = total_ff + 36'(rd_delta_ff);
            if (idx_ff == CW'(2)) tlast_in = rd_time_ff;
            if (idx_ff == count_ff + CW'(1)) dstart = 1'b1;
         end
         ST_EST: begin
            count_in = '0; watching_in = 1'b0; head_in = '0;
            if (est_go) begin
               fling_in = 1'b1;
               vneg_in = est_valid && total_ff[35];
               vmag_in = (est_vel > {9'd0, max_vel_ff}) ? {1'b0, max_vel_ff} : est_vel[31:0];
               last_tick_in = now_ff; tick_valid_in = 1'b1;
            end
         end
         ST_EMIT: begin
            acc_in = Q16_ONE; base_in = {1'b0, friction_ff};
            if (!mul_wait_ff) begin
               mreq = '{start: 1'b1, a: 48'(vmag_ff), b: dt_ff};
               mul_wait_in = 1'b1;
            end else if (mdone) begin
               mul_wait_in = 1'b0;
               if (vneg_ff)
                  out_delta_in = (emit_mag >= 32'h8000_0000) ? 32'sh8000_0000
                                 : -$signed(emit_mag);
               else
                  out_delta_in = (mprod[63:8] + 56'(mprod[7]) >= 56'h7FFF_FFFF)
                                 ? 32'sh7FFF_FFFF : $signed(emit_mag);
               if (vneg_ff && mprod[63:8] + 56'(mprod[7]) >= 56'h8000_0000)
                  out_delta_in = 32'sh8000_0000;
            end
         end
         ST_POW_MUL: begin
            if (n_ff[0]) begin
               if (!mul_wait_ff) begin
                  mreq = '{start: 1'b1, a: 48'(acc_ff), b: 32'(base_ff)};
                  mul_wait_in = 1'b1;
               end else if (mdone) begin
                  mul_wait_in = 1'b0;
                  acc_in = 17'((mprod + 80'd32768) >> 16);
               end
            end
         end
         ST_POW_SQR: begin
            if (!mul_wait_ff) begin
               mreq = '{start: 1'b1, a: 48'(base_ff), b: 32'(base_ff)};
               mul_wait_in = 1'b1;
            end else if (mdone) begin
               mul_wait_in = 1'b0;
               base_in = 17'((mprod + 80'd32768) >> 16);
               n_in = n_ff >> 1;
            end
         end
         ST_DECAY: begin
            if (!mul_wait_ff) begin
               mreq = '{start: 1'b1, a: 48'(vmag_ff), b: 32'(acc_ff)};
               mul_wait_in = 1'b1;
            end else if (mdone) begin
               mul_wait_in = 1'b0;
               vmag_in = 32'((mprod + 80'd32768) >> 16);
               if (vmag_in < {1'b0, stop_vel_ff}) fling_in = 1'b0;
            end
         end
         ST_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0; count_ff <= '0;
         watching_ff <= 1'b0; fling_ff <= 1'b0;
         vneg_ff <= 1'b0; vmag_ff <= '0;
         last_sample_ff <= '0; last_tick_ff <= '0; tick_valid_ff <= 1'b0;
         mul_wait_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in; count_ff <= count_in;
         watching_ff <= watching_in; fling_ff <= fling_in;
         vneg_ff <= vneg_in; vmag_ff <= vmag_in;
         last_sample_ff <= last_sample_in; last_tick_ff <= last_tick_in;
         tick_valid_ff <= tick_valid_in;
         mul_wait_ff <= mul_wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff <= now_in; dt_ff <= dt_in; n_ff <= n_in;
      acc_ff <= acc_in; base_ff <= base_in; total_ff <= total_in;
      idx_ff <= idx_in; t0_ff <= t0_in; tlast_ff <= tlast_in;
      out_delta_ff <= out_delta_in;
      if (state_ff == ST_DONE) begin
         out_fling_ff <= fling_ff;
         out_watch_ff <= watching_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_scroll_delta = out_delta_ff;
   assign rsp_fling_active = out_fling_ff;
   assign rsp_gesture_watching = out_watch_ff;

   // a fling and a watched gesture never coexist after an item
   property p_excl;
      @(posedge clock) disable iff (reset) rsp_valid |-> !(rsp_fling_active && rsp_gesture_watching);
   endproperty
   assert property (p_excl) else $error("fling and watching both set");

   property p_count;
      @(posedge clock) disable iff (reset) count_ff <= DEPTH_C;
   endproperty
   assert property (p_count) else $error("window count overflow");

   property p_idle_vel;
      @(posedge clock) disable iff (reset) (state_ff == ST_IDLE && !fling_ff && !watching_ff)
         |-> count_ff == '0;
   endproperty
   assert property (p_idle_vel) else $error("window kept while idle");
endmodule

[verif/tb_kinetic_scroll_fling_tracker_top.sv]
module tb_kinetic_scroll_fling_tracker_top;
   import ksft_pkg::*;

   localparam int WIN_DEPTH = 8;
   localparam int IDLE_LIMIT = 6000;
   localparam int HOLD_CYCLES = 500;

   typedef struct {
      bit                 op;
      logic signed [23:0] delta;
      bit                 touch;
      logic [31:0]        stamp;
   } scroll_req_type;

   typedef struct {
      logic signed [31:0] scroll;
      bit                 fling;
      bit                 watch;
   } scroll_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_operation = 0;
   logic signed [23:0] req_sample_delta = '0;
   logic req_is_touchpad = 0;
   logic [31:0] req_time_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_scroll_delta;
   logic rsp_fling_active;
   logic rsp_gesture_watching;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   scroll_req_type pending_reqs[$];
   scroll_rsp_type expected_rsps[$];
   int errors = 0;
   int rsp_count = 0;
   int quiet_cycles = 0;
   logic [31:0] cur_time = 32'd1000;

   // predictor state and registers
   longint unsigned cfg_friction, cfg_stop, cfg_idle, cfg_min, cfg_max;
   logic signed [23:0] win_delta[WIN_DEPTH];
   logic [31:0] win_time[WIN_DEPTH];
   int win_count;
   bit watching, flinging, tick_valid;
   longint fling_vel;
   logic [31:0] last_sample, last_tick;

   kinetic_scroll_fling_tracker_top #(.WINDOW_DEPTH(WIN_DEPTH)) uut (.*);

   always #5 clock = ~clock;

   function automatic longint unsigned friction_pow(longint unsigned base, logic [31:0] n);
      longint unsigned acc;
      acc = 65536;
      while (n != 0) begin
         if (n[0]) acc = (acc * base + 32768) >> 16;
         base = (base * base + 32768) >> 16;
         n = n >> 1;
      end
      return acc;
   endfunction

   // distance for dt, then friction decay and stop test
   function automatic longint coast_step(logic [31:0] dt);
      bit neg;
      longint unsigned m, d;
      longint move;
      neg = fling_vel < 0;
      m = neg ? -fling_vel : fling_vel;
      d = (m * longint'(dt) + 128) >> 8;
      if (neg) move = (d >= 64'd2147483648) ? -64'sd2147483648 : -longint'(d);
      else move = (d >= 64'd2147483647) ? 64'sd2147483647 : longint'(d);
      m = (m * friction_pow(cfg_friction, dt) + 32768) >> 16;
      fling_vel = neg ? -longint'(m) : longint'(m);
      if (m < cfg_stop) flinging = 0;
      return move;
   endfunction

   function automatic scroll_rsp_type fling_predict(scroll_req_type it);
      scroll_rsp_type r;
      longint move, total;
      longint unsigned vm, mag;
      logic [31:0] dt, idle, span;
      bit neg;
      move = 0;
      if (!it.op) begin
         if (!it.touch) begin
            win_count = 0;
            watching = 0;
         end
         flinging = 0;
         fling_vel = 0;
         tick_valid = 0;
         if (it.touch) begin
            if (win_count < WIN_DEPTH) begin
               win_delta[win_count] = it.delta;
               win_time[win_count] = it.stamp;
               win_count++;
            end else begin
               for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                  win_delta[i] = win_delta[i+1];
                  win_time[i] = win_time[i+1];
               end
               win_delta[WIN_DEPTH-1] = it.delta;
               win_time[WIN_DEPTH-1] = it.stamp;
            end
            last_sample = it.stamp;
            watching = 1;
         end
      end else if (flinging) begin
         dt = tick_valid ? it.stamp - last_tick : 32'd0;
         last_tick = it.stamp;
         tick_valid = 1;
         if (dt != 0) move = coast_step(dt);
      end else if (watching) begin
         idle = it.stamp - last_sample;
         if (idle >= cfg_idle) begin
            vm = 0;
            neg = 0;
            if (win_count >= 2) begin
               span = win_time[win_count-1] - win_time[0];
               if (span != 0) begin
                  total = 0;
                  for (int i = 1; i < win_count; i++) total += longint'(win_delta[i]);
                  neg = total < 0;
                  mag = neg ? -total : total;
                  vm = ((mag << 8) + longint'(span) / 2) / longint'(span);
               end
            end
            win_count = 0;
            watching = 0;
            if (vm >= cfg_min) begin
               if (vm > cfg_max) vm = cfg_max;
               flinging = 1;
               fling_vel = neg ? -longint'(vm) : longint'(vm);
               move = coast_step(idle);
               last_tick = it.stamp;
               tick_valid = 1;
            end
         end
      end
      r.scroll = move[31:0];
      r.fling = flinging;
      r.watch = watching;
      return r;
   endfunction

   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // sender: payload held while stalled
   int send_gap = 0;
   bit send_calm = 0;
   always @(posedge clock) begin
      scroll_req_type it;
      bit nxt;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if ($urandom_range(0, 149) == 0) send_calm = ~send_calm;
         nxt = req_valid;
         if (req_valid && !req_stall) begin
            it.op = req_operation;
            it.delta = req_sample_delta;
            it.touch = req_is_touchpad;
            it.stamp = req_time_ms;
            expected_rsps.push_back(fling_predict(it));
            nxt = 0;
            send_gap = pick_gap(send_calm);
         end
         if (!nxt) begin
            if (send_gap > 0) send_gap--;
            else if (pending_reqs.size() > 0) begin
               it = pending_reqs.pop_front();
               req_operation <= it.op;
               req_sample_delta <= it.delta;
               req_is_touchpad <= it.touch;
               req_time_ms <= it.stamp;
               nxt = 1;
            end
         end
         req_valid <= nxt;
      end
   end

   // receiver stall, with one long hold-off while items keep coming
   int hold_left = 0;
   bit held_once = 0;
   bit rcv_calm = 0;
   always @(posedge clock) begin
      bit s;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if ($urandom_range(0, 149) == 0) rcv_calm = ~rcv_calm;
         if (!held_once && rsp_count >= 150) begin
            held_once = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            s = 1;
         end else if (rcv_calm) s = 0;
         else s = ($urandom_range(0, 99) < 30) ? 1 : (pick_gap(0) > 10);
         rsp_stall <= s;
      end
   end

   // result check
   always @(posedge clock) begin
      scroll_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: delta %0d fling %0b watch %0b", $time,
                     rsp_scroll_delta, rsp_fling_active, rsp_gesture_watching);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_scroll_delta !== e.scroll) begin
               errors++;
               $display("%0t: scroll_delta expected %0d actual %0d", $time, e.scroll,
                        rsp_scroll_delta);
            end
            if (rsp_fling_active !== e.fling) begin
               errors++;
               $display("%0t: fling_active expected %0b actual %0b", $time, e.fling,
                        rsp_fling_active);
            end
            if (rsp_gesture_watching !== e.watch) begin
               errors++;
               $display("%0t: gesture_watching expected %0b actual %0b", $time, e.watch,
                        rsp_gesture_watching);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("kinetic_scroll_fling_tracker_top regression: fail");
         $finish;
      end
   end

   task automatic push_item(bit op, logic signed [23:0] delta, bit touch, logic [31:0] stamp);
      scroll_req_type it;
      it.op = op;
      it.delta = delta;
      it.touch = touch;
      it.stamp = stamp;
      pending_reqs.push_back(it);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_FRICTION: cfg_friction = data[15:0];
         CSR_STOP_VEL: cfg_stop = data[30:0];
         CSR_IDLE_GAP: cfg_idle = data[15:0];
         CSR_MIN_VEL:  cfg_min = data[30:0];
         CSR_MAX_VEL:  cfg_max = data[30:0];
         default: ;
      endcase
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_delta();
      if ($urandom_range(0, 9) == 0) return $urandom();
      return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
   endfunction

   // touchpad samples, ticks before and after the gap, then fling frames
   task automatic add_gesture();
      int n, frames;
      bit sgn;
      logic signed [23:0] d;
      n = $urandom_range(1, 12);
      sgn = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
         cur_time += $urandom_range(0, 20);
         d = rand_delta();
         if ($urandom_range(0, 3) != 0) d = sgn ? -(d & 24'sh7FFF) : (d & 24'sh7FFF);
         push_item(0, d, 1, cur_time);
      end
      if (cfg_idle > 1 && $urandom_range(0, 2) == 0)
         push_item(1, $urandom(), $urandom_range(0, 1), cur_time + 1);
      cur_time += cfg_idle + $urandom_range(0, 6);
      push_item(1, $urandom(), $urandom_range(0, 1), cur_time);
      frames = $urandom_range(0, 15);
      for (int i = 0; i < frames; i++) begin
         if ($urandom_range(0, 29) == 0) cur_time += $urandom();
         else cur_time += $urandom_range(0, 20);
         push_item(1, $urandom(), $urandom_range(0, 1), cur_time);
      end
   endtask

   task automatic add_noise();
      if ($urandom_range(0, 1)) cur_time = $urandom();
      else cur_time += $urandom_range(0, 100);
      push_item($urandom_range(0, 1), $urandom(), $urandom_range(0, 1), cur_time);
   endtask

   task automatic run_phase(int items);
      while (pending_reqs.size() < items) begin
         if ($urandom_range(0, 9) < 8) add_gesture();
         else add_noise();
      end
      drain();
   endtask

   initial begin
      cfg_friction = FRICTION_RST;
      cfg_stop = STOP_VEL_RST;
      cfg_idle = IDLE_GAP_RST;
      cfg_min = MIN_VEL_RST;
      cfg_max = MAX_VEL_RST;
      win_count = 0;
      watching = 0;
      flinging = 0;
      tick_valid = 0;
      fling_vel = 0;
      last_sample = 0;
      last_tick = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: idle tick, cancel, window overflow, gap, fling corners
      push_item(1, 24'sh123456, 1, 32'd1000);
      push_item(0, 24'sh000100, 0, 32'd1001);
      for (int i = 0; i < 10; i++)
         push_item(0, (i % 2) ? 24'sh7FFFFF : 24'sh000800, 1, 32'd1002 + 4 * i);
      push_item(1, 24'sh0, 1, 32'd1050);
      push_item(1, 24'sh0, 0, 32'd1100);
      push_item(1, 24'sh0, 1, 32'd1100);
      push_item(1, 24'sh0, 1, 32'd1116);
      push_item(1, 24'sh0, 1, 32'd1110);
      push_item(0, -24'sh800000, 1, 32'd2000);
      push_item(0, -24'sh800000, 1, 32'd2000);
      push_item(1, 24'sh0, 1, 32'd2100);
      push_item(0, 24'sh0, 1, 32'hFFFF_FFF0);
      push_item(0, -24'sh800000, 1, 32'h0000_0004);
      push_item(1, 24'sh0, 1, 32'h0000_0100);
      push_item(0, 24'sh000400, 0, 32'h0000_0200);
      cur_time = 32'h0000_0300;
      drain();
      run_phase(170);

      // moderate settings, plus a write past the register set
      csr_write(CSR_FRICTION, 32'hFFFF_F000 | $urandom_range(60000, 65535));
      csr_write(CSR_STOP_VEL, $urandom_range(100, 5000));
      csr_write(CSR_IDLE_GAP, $urandom_range(5, 40));
      csr_write(CSR_MIN_VEL, $urandom_range(1000, 20000));
      csr_write(CSR_MAX_VEL, 32'h8000_0000 | $urandom_range(100000, 2000000));
      csr_write(3'd5, $urandom());
      csr_write(3'd7, $urandom());
      run_phase(180);

      // lowest extremes: no friction carry, zero gap, zero bounds
      csr_write(CSR_FRICTION, 32'd0);
      csr_write(CSR_STOP_VEL, 32'd0);
      csr_write(CSR_IDLE_GAP, 32'd0);
      csr_write(CSR_MIN_VEL, 32'd0);
      csr_write(CSR_MAX_VEL, 32'd0);
      run_phase(180);

      // highest extremes, min above max
      csr_write(CSR_FRICTION, 32'hFFFF_FFFF);
      csr_write(CSR_STOP_VEL, 32'h7FFF_FFFF);
      csr_write(CSR_IDLE_GAP, 32'h0000_FFFF);
      csr_write(CSR_MIN_VEL, 32'd100);
      csr_write(CSR_MAX_VEL, 32'h7FFF_FFFF);
      run_phase(90);
      csr_write(CSR_STOP_VEL, 32'd0);
      csr_write(CSR_IDLE_GAP, 32'd20);
      csr_write(CSR_MIN_VEL, 32'h7FFF_FFFF);
      csr_write(CSR_MAX_VEL, 32'd1000);
      run_phase(90);
      csr_write(CSR_MIN_VEL, 32'd5000);
      csr_write(CSR_MAX_VEL, 32'd2000);
      csr_write(CSR_STOP_VEL, 32'd300);
      csr_write(CSR_FRICTION, 32'd65000);
      run_phase(200);

      if (errors == 0)
         $display("kinetic_scroll_fling_tracker_top regression: pass");
      else
         $display("kinetic_scroll_fling_tracker_top regression: fail");
      $finish;
   end

endmodule
